/* hdl/pressure_sensor_compensation_top_assert.svh */
// assertion macros for the pressure sensor compensation block
// included by the top level; no other dependencies
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/psc_pkg.sv */
// shared widths, constants and register codes for pressure compensation
// no dependencies
`timescale 1ns / 1ps

package psc_pkg;

    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 19;
    localparam int PRES_W = 26;
    localparam int IDX_W  = 3;

    // temperature reference point, 20.00 C in hundredths
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

    // calibration register codes
    typedef enum logic [IDX_W-1:0] {
        CFG_SENS_AT_REF       = 3'd0,
        CFG_OFFSET_AT_REF     = 3'd1,
        CFG_SENS_TEMP_COEFF   = 3'd2,
        CFG_OFFSET_TEMP_COEFF = 3'd3,
        CFG_REF_TEMP_CODE     = 3'd4,
        CFG_TEMP_SENSITIVITY  = 3'd5
    } t_cfg_idx;

endpackage

/* hdl/pressure_sensor_compensation_top.sv */
// Pressure sensor second-order compensation. One raw pair (temperature D2,
// pressure D1) is taken per clock unless stalled, and the compensated
// temperature (0.01 C) and pressure (0.1 mbar) leave through an 8-stage
// pipeline; the depth is set by the square of the temperature deviation,
// which needs the first-order temperature, and by the 24 x 38 bit pressure
// product that is split into two partial products and summed in a stage of
// its own. A zero reading gives status 1 with zero results. Calibration
// words are to be written through the plain write port while the block is
// idle; the block does not enforce it. Stall from the output side backs up
// stage by stage, so empty stages fill up while a finished result waits.
// depends on psc_pkg and pressure_sensor_compensation_top_assert.svh
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_top_assert.svh"

module pressure_sensor_compensation_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [psc_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [psc_pkg::CAL_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [psc_pkg::RAW_W-1:0]           i_raw_temperature,
    input  logic [psc_pkg::RAW_W-1:0]           i_raw_pressure,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [psc_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic signed [psc_pkg::PRES_W-1:0]   o_pressure_decimbar,
    output logic                                o_status
);

    localparam int NSTG = 8;

    // calibration registers
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            case (psc_pkg::t_cfg_idx'(i_cfg_idx))
                psc_pkg::CFG_SENS_AT_REF:       r_c1 <= i_cfg_data;
                psc_pkg::CFG_OFFSET_AT_REF:     r_c2 <= i_cfg_data;
                psc_pkg::CFG_SENS_TEMP_COEFF:   r_c3 <= i_cfg_data;
                psc_pkg::CFG_OFFSET_TEMP_COEFF: r_c4 <= i_cfg_data;
                psc_pkg::CFG_REF_TEMP_CODE:     r_c5 <= i_cfg_data;
                psc_pkg::CFG_TEMP_SENSITIVITY:  r_c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per-stage valid bits and advance chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: dT and zero-reading check
    logic signed [24:0] w_dt;
    logic signed [24:0] r_s1_dt;
    logic [23:0]        r_s1_d1;
    logic               r_s1_zero;

    assign w_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_dt   <= w_dt;
            r_s1_d1   <= i_raw_pressure;
            r_s1_zero <= (i_raw_temperature == '0) || (i_raw_pressure == '0);
        end
    end

    // stage 2: products of dT
    logic signed [41:0] w_dtc6, w_c4dt, w_c3dt;
    logic signed [49:0] w_dtsq;
    logic signed [41:0] r_s2_dtc6, r_s2_c4dt, r_s2_c3dt;
    logic [48:0]        r_s2_dtsq;
    logic [23:0]        r_s2_d1;
    logic               r_s2_zero;

    assign w_dtc6 = r_s1_dt * $signed({1'b0, r_c6});
    assign w_c4dt = r_s1_dt * $signed({1'b0, r_c4});
    assign w_c3dt = r_s1_dt * $signed({1'b0, r_c3});
    assign w_dtsq = r_s1_dt * r_s1_dt;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_dtc6 <= w_dtc6;
            r_s2_c4dt <= w_c4dt;
            r_s2_c3dt <= w_c3dt;
            r_s2_dtsq <= w_dtsq[48:0];
            r_s2_d1   <= r_s1_d1;
            r_s2_zero <= r_s1_zero;
        end
    end

    // stage 3: first-order temperature, T2, offset and sensitivity bases
    logic signed [18:0] w_dev;
    logic [50:0]        w_dtsq3;
    logic [17:0]        w_t2;
    logic signed [36:0] w_offb, w_sensb;
    logic signed [18:0] r_s3_dev, r_s3_temp;
    logic [17:0]        r_s3_t2;
    logic signed [36:0] r_s3_offb, r_s3_sensb;
    logic [23:0]        r_s3_d1;
    logic               r_s3_zero;

    assign w_dev   = $signed(r_s2_dtc6[41:23]);
    assign w_dtsq3 = {2'b00, r_s2_dtsq} + {1'b0, r_s2_dtsq, 1'b0};
    assign w_t2    = w_dev[18] ? w_dtsq3[50:33] : {5'b0, r_s2_dtsq[48:36]};
    assign w_offb  = $signed({5'b0, r_c2, 16'h0000})
                   + $signed({{2{r_s2_c4dt[41]}}, r_s2_c4dt[41:7]});
    assign w_sensb = $signed({6'b0, r_c1, 15'h0000})
                   + $signed({{3{r_s2_c3dt[41]}}, r_s2_c3dt[41:8]});

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_dev   <= w_dev;
            r_s3_temp  <= psc_pkg::TEMP_REF + w_dev;
            r_s3_t2    <= w_t2;
            r_s3_offb  <= w_offb;
            r_s3_sensb <= w_sensb;
            r_s3_d1    <= r_s2_d1;
            r_s3_zero  <= r_s2_zero;
        end
    end

    // stage 4: square of the deviation, corrected temperature
    logic signed [37:0] w_devsq;
    logic signed [19:0] w_tc;
    logic [34:0]        r_s4_devsq;
    logic               r_s4_neg;
    logic signed [18:0] r_s4_temp;
    logic signed [36:0] r_s4_offb, r_s4_sensb;
    logic [23:0]        r_s4_d1;
    logic               r_s4_zero;

    assign w_devsq = r_s3_dev * r_s3_dev;
    assign w_tc    = $signed({r_s3_temp[18], r_s3_temp}) - $signed({2'b00, r_s3_t2});

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_devsq <= w_devsq[34:0];
            r_s4_neg   <= r_s3_dev[18];
            r_s4_temp  <= w_tc[18:0];
            r_s4_offb  <= r_s3_offb;
            r_s4_sensb <= r_s3_sensb;
            r_s4_d1    <= r_s3_d1;
            r_s4_zero  <= r_s3_zero;
        end
    end

    // stage 5: second-order offset and sensitivity
    logic [36:0]        w_devsq3, w_devsq5;
    logic [35:0]        w_off2;
    logic [33:0]        w_sens2;
    logic signed [37:0] w_off, w_sens;
    logic signed [37:0] r_s5_off, r_s5_sens;
    logic signed [18:0] r_s5_temp;
    logic [23:0]        r_s5_d1;
    logic               r_s5_zero;

    assign w_devsq3 = {2'b00, r_s4_devsq} + {1'b0, r_s4_devsq, 1'b0};
    assign w_devsq5 = {2'b00, r_s4_devsq} + {r_s4_devsq, 2'b00};
    assign w_off2   = r_s4_neg ? w_devsq3[36:1] : {5'b0, r_s4_devsq[34:4]};
    assign w_sens2  = r_s4_neg ? w_devsq5[36:3] : '0;
    assign w_off    = $signed({r_s4_offb[36], r_s4_offb}) - $signed({2'b00, w_off2});
    assign w_sens   = $signed({r_s4_sensb[36], r_s4_sensb}) - $signed({4'b0, w_sens2});

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_off  <= w_off;
            r_s5_sens <= w_sens;
            r_s5_temp <= r_s4_temp;
            r_s5_d1   <= r_s4_d1;
            r_s5_zero <= r_s4_zero;
        end
    end

    // stage 6: pressure partial products, low and high halves of SENS
    logic [42:0]        w_plo;
    logic signed [43:0] w_phi;
    logic [42:0]        r_s6_plo;
    logic signed [43:0] r_s6_phi;
    logic signed [37:0] r_s6_off;
    logic signed [18:0] r_s6_temp;
    logic               r_s6_zero;

    assign w_plo = r_s5_d1 * r_s5_sens[18:0];
    assign w_phi = $signed({1'b0, r_s5_d1}) * $signed(r_s5_sens[37:19]);

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s6_plo  <= w_plo;
            r_s6_phi  <= w_phi;
            r_s6_off  <= r_s5_off;
            r_s6_temp <= r_s5_temp;
            r_s6_zero <= r_s5_zero;
        end
    end

    // stage 7: full product, scaled down
    logic signed [63:0] w_prod;
    logic signed [42:0] r_s7_psh;
    logic signed [37:0] r_s7_off;
    logic signed [18:0] r_s7_temp;
    logic               r_s7_zero;

    assign w_prod = $signed({r_s6_phi[43], r_s6_phi, 19'h0}) + $signed({21'h0, r_s6_plo});

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_s7_psh  <= w_prod[63:21];
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
            r_s7_zero <= r_s6_zero;
        end
    end

    // stage 8: pressure and output register
    logic signed [44:0] w_diff;
    logic signed [psc_pkg::TEMP_W-1:0] r_o_temp;
    logic signed [psc_pkg::PRES_W-1:0] r_o_pres;
    logic                              r_o_status;

    assign w_diff = $signed({{2{r_s7_psh[42]}}, r_s7_psh})
                  - $signed({{7{r_s7_off[37]}}, r_s7_off});

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r_o_temp   <= r_s7_zero ? '0 : r_s7_temp;
            r_o_pres   <= r_s7_zero ? '0 : $signed(w_diff[38:13]);
            r_o_status <= r_s7_zero;
        end
    end

    assign o_valid             = r_vld[NSTG-1];
    assign o_temperature_centi = r_o_temp;
    assign o_pressure_decimbar = r_o_pres;
    assign o_status            = r_o_status;

    // checks
    `PSC_ASSERT_IMPLIES(a_zero_results, i_clk, i_rst_n,
        o_valid && o_status, (o_temperature_centi == '0) && (o_pressure_decimbar == '0),
        "zero-reading result carries non-zero fields")
    `PSC_ASSERT_IMPLIES(a_stall_source, i_clk, i_rst_n,
        o_stall, o_valid && i_stall, "input stalled without a stalled full pipeline")
    `PSC_ASSERT_NEXT(a_zero_flag, i_clk, i_rst_n,
        i_valid && !o_stall && ((i_raw_temperature == '0) || (i_raw_pressure == '0)),
        r_vld[0] && r_s1_zero, "zero reading not flagged in first stage")

endmodule
